[hdl/u2u_pkg.sv]
// Types, constants and the code point release function for the
// UTF-8 to UTF-16 stream decoder. No dependencies.
`timescale 1ns / 1ps
package u2u_pkg;

  localparam logic [20:0] CodeMax   = 21'h10FFFF;
  localparam logic [15:0] SurrLo    = 16'hD800;
  localparam logic [15:0] SurrEnd   = 16'hE000;
  localparam logic [5:0]  HiSurrTag = 6'b110110;
  localparam logic [5:0]  LoSurrTag = 6'b110111;
  localparam int unsigned MaxUnits  = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } out_t;

  // decoder state carried between bytes
  typedef struct packed {
    logic [20:0] acc;
    logic        too_large;
    logic        pending;
  } dec_state_t;

  // units given off by one release, in order
  typedef struct packed {
    logic [1:0]  cnt;
    logic [15:0] u0;
    logic [15:0] u1;
  } rel_t;

  // Releases the held value: nothing, one BMP unit or a surrogate pair.
  function automatic rel_t release_value(dec_state_t s);
    rel_t        r;
    logic [20:0] w;
    r.cnt = 2'd0;
    r.u0  = s.acc[15:0];
    r.u1  = 16'h0000;
    w     = s.acc - 21'h010000;
    if (s.pending && !s.too_large && s.acc <= CodeMax) begin
      if (s.acc[20:16] != 5'd0) begin
        r.cnt = 2'd2;
        r.u0  = {HiSurrTag, w[19:10]};
        r.u1  = {LoSurrTag, w[9:0]};
      end else if (s.acc[15:0] < SurrLo || s.acc[15:0] >= SurrEnd) begin
        r.cnt = 2'd1;
      end
    end
    return r;
  endfunction

endpackage

[hdl/u2u_dec.sv]
// Per-byte decode: state update and the up to four code units one byte
// releases. Depends on u2u_pkg.
`timescale 1ns / 1ps
module u2u_dec (
  input  u2u_pkg::dec_state_t state_i,
  input  u2u_pkg::in_t        item_i,
  output u2u_pkg::dec_state_t state_o,
  output logic [2:0]          cnt_o,
  output logic [15:0]         unit_o [u2u_pkg::MaxUnits]
);

  u2u_pkg::dec_state_t mid;
  u2u_pkg::rel_t       rel_a;
  u2u_pkg::rel_t       rel_b;
  logic [26:0]         shifted;
  logic [7:0]          b;

  assign b       = item_i.data_byte;
  assign shifted = {state_i.acc, b[5:0]};

  always_comb begin
    mid   = state_i;
    rel_a = '0;
    if (b[7:6] == 2'b10) begin
      mid.acc       = shifted[20:0];
      mid.too_large = state_i.too_large || (shifted > {6'd0, u2u_pkg::CodeMax});
      mid.pending   = 1'b1;
    end else begin
      // a lead byte first lets go of what was built so far
      rel_a = u2u_pkg::release_value(state_i);
      case (1'b1)
        (b <= 8'h7F): mid.acc = {13'd0, b};
        (b <= 8'hDF): mid.acc = {16'd0, b[4:0]};
        (b <= 8'hEF): mid.acc = {17'd0, b[3:0]};
        default:      mid.acc = {18'd0, b[2:0]};
      endcase
      mid.too_large = 1'b0;
      mid.pending   = 1'b1;
    end
  end

  always_comb begin
    rel_b   = '0;
    state_o = mid;
    if (item_i.end_of_string) begin
      rel_b   = u2u_pkg::release_value(mid);
      state_o = '0;
    end
  end

  always_comb begin
    cnt_o     = {1'b0, rel_a.cnt} + {1'b0, rel_b.cnt};
    unit_o[0] = (rel_a.cnt != 2'd0) ? rel_a.u0 : rel_b.u0;
    unit_o[1] = (rel_a.cnt == 2'd2) ? rel_a.u1 :
                (rel_a.cnt == 2'd1) ? rel_b.u0 : rel_b.u1;
    unit_o[2] = (rel_a.cnt == 2'd2) ? rel_b.u0 : rel_b.u1;
    unit_o[3] = rel_b.u1;
  end

endmodule

[hdl/utf8_to_utf16_stream_decoder_top.sv]
// Top level of the UTF-8 to UTF-16 stream decoder: input register, decode,
// and a result group that drains one code unit per transaction.
// Depends on u2u_pkg and u2u_dec.
// A byte accepted into the input register is decoded and loaded into the result group,
// which shows its first code unit (two register stages: input register, result group).
// Throughput: one byte per cycle while out_ready_i is high and each byte gives at most
// one unit; a byte that gives k units holds the result group for k output transactions.
// Reset clears the decoder state and empties the input register and the result group.
`timescale 1ns / 1ps
module utf8_to_utf16_stream_decoder_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  u2u_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output u2u_pkg::out_t out_data_o
);

  logic                inq_valid_q;
  u2u_pkg::in_t        inq_data_q;
  u2u_pkg::dec_state_t state_q, state_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [15:0]         grp_q [u2u_pkg::MaxUnits];
  logic [15:0]         grp_d [u2u_pkg::MaxUnits];
  logic [2:0]          dec_cnt;
  logic [15:0]         dec_unit [u2u_pkg::MaxUnits];
  logic                grp_free;
  logic                load;
  logic                out_fire;

  u2u_dec u_dec (
    .state_i (state_q),
    .item_i  (inq_data_q),
    .state_o (state_d),
    .cnt_o   (dec_cnt),
    .unit_o  (dec_unit)
  );

  assign out_fire    = out_valid_o && out_ready_i;
  assign grp_free    = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_ready_i);
  assign load        = inq_valid_q && grp_free;
  assign in_ready_o  = !inq_valid_q || grp_free;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o.code_unit = grp_q[0];
  assign out_data_o.last_unit = (cnt_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      inq_valid_q <= 1'b1;
    end else if (load) begin
      inq_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (load) begin
      state_q <= state_d;
    end
  end

  // result group: load a fresh set of units, or shift one out per transaction
  always_comb begin
    cnt_d = cnt_q;
    grp_d = grp_q;
    if (load) begin
      cnt_d = dec_cnt;
      grp_d = dec_unit;
    end else if (out_fire) begin
      cnt_d = cnt_q - 3'd1;
      for (int i = 0; i < u2u_pkg::MaxUnits - 1; i++) begin
        grp_d[i] = grp_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result group count out of range");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && inq_data_q.end_of_string |=> state_q == '0)
    else $error("state not cleared after end of string");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inq_valid_q && !grp_free |=> inq_valid_q && $stable(inq_data_q))
    else $error("input register lost a stalled byte");

  a_load_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !(in_valid_i && in_ready_o) |=> !inq_valid_q)
    else $error("input register kept a byte already decoded");

endmodule

[tb/utf8_to_utf16_stream_decoder_top_tb.sv]
// Self-checking testbench for utf8_to_utf16_stream_decoder_top: a byte driver,
// a code unit predictor and a unit monitor with random gaps on both sides.
// Depends on u2u_pkg and the decoder RTL.
`timescale 1ns / 1ps
module utf8_to_utf16_stream_decoder_top_tb;

  localparam logic [20:0] CodeLimit   = 21'h10FFFF;
  localparam logic [20:0] PlaneOne    = 21'h010000;
  localparam logic [20:0] SurrogateLo = 21'h00D800;
  localparam logic [20:0] SurrogateHi = 21'h00E000;
  localparam logic [15:0] HighHalf    = 16'hD800;
  localparam logic [15:0] LowHalf     = 16'hDC00;
  localparam int unsigned RandomBytes = 400;
  localparam int unsigned DrainCycles = 20;

  logic           clk_i;
  logic           rst_ni    = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  u2u_pkg::in_t   in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  u2u_pkg::out_t  out_data;

  u2u_pkg::in_t   byte_queue[$];
  logic [7:0]     string_bytes[$];
  u2u_pkg::out_t  expected_units[$];
  logic [15:0]    step_units[$];

  // predictor copy of the decoder state
  logic [20:0]    code_acc  = '0;
  logic           code_big  = 1'b0;
  logic           code_held = 1'b0;

  int unsigned    gap_left   = 0;
  int unsigned    stall_left = 0;
  int unsigned    errors     = 0;

  utf8_to_utf16_stream_decoder_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // mostly no wait, so back-to-back stretches occur between the gaps
  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 2) == 0) begin
      return $urandom_range(0, 19);
    end
    return 0;
  endfunction

  // units for the held code point, if it survives the range checks
  task automatic release_code_point();
    logic [20:0] w;
    if (code_held && !code_big && code_acc <= CodeLimit) begin
      if (code_acc >= PlaneOne) begin
        w = code_acc - PlaneOne;
        step_units.insert(step_units.size(), HighHalf + {6'd0, w[19:10]});
        step_units.insert(step_units.size(), LowHalf + {6'd0, w[9:0]});
      end else if (code_acc < SurrogateLo || code_acc >= SurrogateHi) begin
        step_units.insert(step_units.size(), code_acc[15:0]);
      end
    end
  endtask

  task automatic predict_units(input u2u_pkg::in_t item);
    logic [26:0]   shifted;
    u2u_pkg::out_t unit;
    step_units.delete();
    if (item.data_byte[7:6] == 2'b10) begin
      // continuation: no check that one was expected
      shifted = {code_acc, item.data_byte[5:0]};
      if (shifted > {6'd0, CodeLimit}) begin
        code_big = 1'b1;
      end
      code_acc  = shifted[20:0];
      code_held = 1'b1;
    end else begin
      release_code_point();
      if (!item.data_byte[7]) begin
        code_acc = {13'd0, item.data_byte};
      end else if (!item.data_byte[5]) begin
        code_acc = {16'd0, item.data_byte[4:0]};
      end else if (!item.data_byte[4]) begin
        code_acc = {17'd0, item.data_byte[3:0]};
      end else begin
        code_acc = {18'd0, item.data_byte[2:0]};
      end
      code_big  = 1'b0;
      code_held = 1'b1;
    end
    if (item.end_of_string) begin
      release_code_point();
      code_acc  = '0;
      code_big  = 1'b0;
      code_held = 1'b0;
    end
    foreach (step_units[i]) begin
      unit.code_unit = step_units[i];
      unit.last_unit = (i == step_units.size() - 1);
      expected_units.insert(expected_units.size(), unit);
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eos);
    u2u_pkg::in_t item;
    item.data_byte     = b;
    item.end_of_string = eos;
    byte_queue.insert(byte_queue.size(), item);
  endtask

  // UTF-8 form of cp in len bytes; longer than needed gives an overlong form
  task automatic encode_char(input logic [20:0] cp, input int unsigned len);
    logic wide_lead;
    wide_lead = 1'($urandom_range(0, 1));
    case (len)
      1: begin
        string_bytes.insert(string_bytes.size(), {1'b0, cp[6:0]});
      end
      2: begin
        string_bytes.insert(string_bytes.size(), {3'b110, cp[10:6]});
        string_bytes.insert(string_bytes.size(), {2'b10, cp[5:0]});
      end
      3: begin
        string_bytes.insert(string_bytes.size(), {4'b1110, cp[15:12]});
        string_bytes.insert(string_bytes.size(), {2'b10, cp[11:6]});
        string_bytes.insert(string_bytes.size(), {2'b10, cp[5:0]});
      end
      default: begin
        // leads 0xF8..0xFF decode the same as 0xF0..0xF7
        string_bytes.insert(string_bytes.size(), {4'b1111, wide_lead, cp[20:18]});
        string_bytes.insert(string_bytes.size(), {2'b10, cp[17:12]});
        string_bytes.insert(string_bytes.size(), {2'b10, cp[11:6]});
        string_bytes.insert(string_bytes.size(), {2'b10, cp[5:0]});
      end
    endcase
  endtask

  initial begin : stimulus
    int unsigned n_random;
    int unsigned kind;
    int unsigned len;
    logic [20:0] cp;

    // directed strings
    push_byte(8'h41, 1'b0); push_byte(8'h7F, 1'b0);
    // overlong zero gives unit 0
    push_byte(8'hC0, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hDF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'hAC, 1'b0);
    // lone surrogate is dropped
    push_byte(8'hED, 1'b0); push_byte(8'hA0, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hF0, 1'b0); push_byte(8'h9F, 1'b0); push_byte(8'h98, 1'b0);
    push_byte(8'h80, 1'b0);
    // 0x110000, string ends on a continuation
    push_byte(8'hF4, 1'b0); push_byte(8'h90, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b1);
    // stray continuation, then shift overflow that must stay sticky
    push_byte(8'h80, 1'b0);
    push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hFF, 1'b1);

    n_random = 0;
    while (n_random < RandomBytes) begin
      kind = $urandom_range(0, 9);
      string_bytes.delete();
      if (kind == 0) begin
        repeat ($urandom_range(1, 6)) begin
          string_bytes.insert(string_bytes.size(), 8'($urandom_range(1, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 7))
            0: begin cp = 21'($urandom_range(1, 'h7F)); len = 1; end
            1: begin cp = 21'($urandom_range('h80, 'h7FF)); len = 2; end
            2: begin cp = 21'($urandom_range('h800, 'hFFFF)); len = 3; end
            3: begin cp = 21'($urandom_range('hD7F0, 'hE010)); len = 3; end
            4, 5: begin cp = 21'($urandom_range('h10000, 'h10FFFF)); len = 4; end
            6: begin
              if ($urandom_range(0, 1) == 0) begin
                cp = 21'($urandom_range('h10FFFC, 'h110003));
              end else begin
                cp = 21'($urandom_range('h110000, 'h1FFFFF));
              end
              len = 4;
            end
            default: begin
              cp  = 21'($urandom_range(0, 'h7FF));
              len = $urandom_range(2, 4);
            end
          endcase
          encode_char(cp, len);
          // broken sequences: truncated or with extra continuations
          if (kind == 1) begin
            if ($urandom_range(0, 1) == 0 && len > 1) begin
              void'(string_bytes.pop_back());
            end else begin
              repeat ($urandom_range(1, 3)) begin
                string_bytes.insert(string_bytes.size(), {2'b10, 6'($urandom)});
              end
            end
          end
        end
      end
      foreach (string_bytes[i]) begin
        if (kind == 0) begin
          push_byte(string_bytes[i], $urandom_range(0, 3) == 0);
        end else begin
          // kind 2 runs on into the next string without an end mark
          push_byte(string_bytes[i], kind != 2 && i == string_bytes.size() - 1);
        end
      end
      n_random += string_bytes.size();
    end

    wait (rst_ni);
    while (byte_queue.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_units.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // byte driver; prediction happens on each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic        free;
    int unsigned gap_next;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left <= 0;
    end else begin
      free     = !in_valid || in_ready;
      gap_next = gap_left;
      if (in_valid && in_ready) begin
        predict_units(in_data);
        gap_next = draw_gap();
      end
      if (free) begin
        if (gap_next != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_next - 1;
        end else if (byte_queue.size() != 0) begin
          in_data  <= byte_queue.pop_front();
          in_valid <= 1'b1;
          gap_left <= 0;
        end else begin
          in_valid <= 1'b0;
          gap_left <= 0;
        end
      end
    end
  end

  // unit monitor with random back-pressure after each transaction
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    u2u_pkg::out_t want;
    int unsigned   stall;
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_units.size() == 0) begin
        $display("%0t: unexpected unit, expected none, actual %h last %b",
                 $time, out_data.code_unit, out_data.last_unit);
        errors <= errors + 1;
      end else begin
        want = expected_units.pop_front();
        if (out_data.code_unit !== want.code_unit) begin
          $display("%0t: code_unit mismatch, expected %h, actual %h",
                   $time, want.code_unit, out_data.code_unit);
          errors <= errors + 1;
        end else if (out_data.last_unit !== want.last_unit) begin
          $display("%0t: last_unit mismatch, expected %b, actual %b",
                   $time, want.last_unit, out_data.last_unit);
          errors <= errors + 1;
        end
      end
      stall = draw_gap();
      if (stall != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall - 1;
      end
    end else if (!out_ready) begin
      if (stall_left == 0) begin
        out_ready <= 1'b1;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

endmodule
